// File: rtl/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types and constants of the cubic B-spline evaluator.
// ----------------------------------------------------------------------------
package cbe_pkg;

	localparam int MAX_KNOTS_DEF    = 256;
	localparam int MAX_CHANNELS_DEF = 64;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int QUEUE_DEPTH      = 4;

	// widest fields a command can need over the whole parameter range
	localparam int ROW_MAXW = 13;
	localparam int K_MAXW   = 12;
	localparam int CH_MAXW  = 6;
	localparam int U_MAXW   = 25;

	// ceil(2^34 / 6): x / 6 == (x * RECIP6) >> 34 for any 32-bit x
	localparam logic [31:0] RECIP6       = 32'hAAAA_AAAB;
	localparam int          RECIP6_SHIFT = 34;

	typedef enum logic [1:0] {
		REQ_KNOT = 2'd0,
		REQ_CP   = 2'd1,
		REQ_EVAL = 2'd2,
		REQ_NOP  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		REG_END_TIME = 2'd0,
		REG_KNOT_CNT = 2'd1,
		REG_CHAN_CNT = 2'd2,
		REG_NC_MASK  = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		F_IDLE, F_RD, F_CMP, F_RD2, F_NXT, F_DC, F_WC, F_DN, F_WN, F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		D_IDLE, D_RUN, D_DONE
	} div_state_t;

	typedef enum logic [1:0] {
		B_IDLE, B_POW, B_MAC, B_OUT
	} back_state_t;

	typedef enum logic [3:0] {
		P_U2, P_U3, P_V2, P_V3, P_SUM, P_W0, P_W1, P_W2, P_W3
	} pow_step_t;

	// one entry of the queue between front and back
	typedef struct packed {
		logic                is_eval;
		logic [ROW_MAXW-1:0] row;
		logic [CH_MAXW-1:0]  ch;
		logic [31:0]         value;
		logic [K_MAXW-1:0]   k;
		logic [U_MAXW-1:0]   u_c;
		logic [U_MAXW-1:0]   u_n;
	} cmd_t;

endpackage

// File: rtl/cbe_div.sv
// ----------------------------------------------------------------------------
// cbe_div
// Radix-2 restoring divider for the normalized segment parameter, clamped 0..1.
// ----------------------------------------------------------------------------
module cbe_div #(
	parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [33:0]   num,
	input  logic signed [33:0]   den,
	output logic                 done,
	output logic [FRAC_BITS:0]   quot
);

	localparam int CW = $clog2(FRAC_BITS);
	localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS+1)'(1) << FRAC_BITS;

	cbe_pkg::div_state_t state_q, state_d;
	logic [32:0]        rem_q;
	logic [33:0]        den_q;
	logic [FRAC_BITS:0] quot_q;
	logic [CW-1:0]      cnt_q;
	logic [33:0]        rem2;
	logic               trivial;

	assign rem2    = {rem_q, 1'b0};
	assign trivial = (num <= 0) || (den <= 0) || (num >= den);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cbe_pkg::D_IDLE: begin
				if (start) state_d = trivial ? cbe_pkg::D_DONE : cbe_pkg::D_RUN;
			end
			cbe_pkg::D_RUN: begin
				if (cnt_q == CW'(FRAC_BITS - 1)) state_d = cbe_pkg::D_DONE;
			end
			cbe_pkg::D_DONE: state_d = cbe_pkg::D_IDLE;
			default: state_d = cbe_pkg::D_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = (state_q == cbe_pkg::D_DONE);
		quot = quot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cbe_pkg::D_IDLE;
		else         state_q <= state_d;
	end

	// one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == cbe_pkg::D_IDLE && start) begin
			cnt_q <= '0;
			den_q <= den;
			rem_q <= num[32:0];
			if (num <= 0 || den <= 0) quot_q <= '0;
			else if (num >= den)      quot_q <= ONE_Q;
			else                      quot_q <= '0;
		end else if (state_q == cbe_pkg::D_RUN) begin
			cnt_q <= cnt_q + 1'b1;
			if (rem2 >= den_q) begin
				rem_q  <= 33'(rem2 - den_q);
				quot_q <= {quot_q[FRAC_BITS-1:0], 1'b1};
			end else begin
				rem_q  <= rem2[32:0];
				quot_q <= {quot_q[FRAC_BITS-1:0], 1'b0};
			end
		end
	end

endmodule

// File: rtl/cbe_front.sv
// ----------------------------------------------------------------------------
// cbe_front
// Takes items, keeps the knot table, finds the segment and divides the offset.
// ----------------------------------------------------------------------------
module cbe_front #(
	parameter int MAX_KNOTS    = cbe_pkg::MAX_KNOTS_DEF,
	parameter int MAX_CHANNELS = cbe_pkg::MAX_CHANNELS_DEF,
	parameter int FRAC_BITS    = cbe_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [1:0]   req_type,
	input  logic [8:0]   table_index,
	input  logic [5:0]   channel_select,
	input  logic [31:0]  write_value,
	input  logic [31:0]  query_time,
	input  logic [31:0]  end_time,
	input  logic [8:0]   knot_count,
	output logic         q_push,
	output cbe_pkg::cmd_t q_data,
	input  logic         q_full
);

	localparam int KW = $clog2(MAX_KNOTS);
	localparam int LW = $clog2(MAX_KNOTS + 1);

	cbe_pkg::front_state_t state_q, state_d;
	logic [31:0]        knot_mem [MAX_KNOTS];
	logic [31:0]        rdata_q;
	logic [KW-1:0]      rd_addr;
	logic [LW-1:0]      len_eff;
	logic [31:0]        t_q;
	logic [KW-1:0]      idx_q, k_q;
	logic [31:0]        base_q;
	logic               last_q;
	logic signed [33:0] num_q, len_c_q, len_n_q;
	logic [FRAC_BITS:0] u_c_q, u_n_q;
	logic               accept, hit, knot_we, cp_ok;
	logic signed [33:0] base_x, nxt_x, end_x;
	logic               div_start, div_done;
	logic signed [33:0] div_den;
	logic [FRAC_BITS:0] div_q;

	assign accept = push && !full;
	assign hit    = $signed({1'b0, t_q}) > $signed({rdata_q[31], rdata_q});
	assign base_x = $signed({{2{base_q[31]}}, base_q});
	assign nxt_x  = $signed({{2{rdata_q[31]}}, rdata_q});
	assign end_x  = $signed({2'b00, end_time});

	assign knot_we = accept && req_type == cbe_pkg::REQ_KNOT
		&& 32'(table_index) < 32'(MAX_KNOTS);
	assign cp_ok   = 32'(table_index) < 32'(MAX_KNOTS + 3)
		&& 32'(channel_select) < 32'(MAX_CHANNELS);

	// knot count clamped to 1..MAX_KNOTS
	always_comb begin
		if (knot_count == 9'd0)                    len_eff = LW'(1);
		else if (32'(knot_count) > 32'(MAX_KNOTS)) len_eff = LW'(MAX_KNOTS);
		else                                       len_eff = LW'(knot_count);
	end

	// knot table, registered read
	always_ff @(posedge clk) begin
		if (knot_we) knot_mem[KW'(table_index)] <= write_value;
		rdata_q <= knot_mem[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cbe_pkg::F_IDLE: begin
				if (accept && req_type == cbe_pkg::REQ_EVAL) state_d = cbe_pkg::F_RD;
			end
			cbe_pkg::F_RD:  state_d = cbe_pkg::F_CMP;
			cbe_pkg::F_CMP: state_d = (hit || idx_q == '0) ? cbe_pkg::F_RD2 : cbe_pkg::F_RD;
			cbe_pkg::F_RD2: state_d = cbe_pkg::F_NXT;
			cbe_pkg::F_NXT: state_d = cbe_pkg::F_DC;
			cbe_pkg::F_DC:  state_d = cbe_pkg::F_WC;
			cbe_pkg::F_WC:  if (div_done) state_d = cbe_pkg::F_DN;
			cbe_pkg::F_DN:  state_d = cbe_pkg::F_WN;
			cbe_pkg::F_WN:  if (div_done) state_d = cbe_pkg::F_PUSH;
			cbe_pkg::F_PUSH: if (!q_full) state_d = cbe_pkg::F_IDLE;
			default: state_d = cbe_pkg::F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		full      = (state_q != cbe_pkg::F_IDLE) || q_full;
		rd_addr   = (state_q == cbe_pkg::F_RD2) ? (last_q ? '0 : KW'(k_q + 1'b1)) : idx_q;
		div_start = (state_q == cbe_pkg::F_DC) || (state_q == cbe_pkg::F_DN);
		div_den   = (state_q == cbe_pkg::F_DN) ? len_n_q : len_c_q;
		q_data         = '0;
		q_push         = 1'b0;
		if (state_q == cbe_pkg::F_PUSH) begin
			q_push       = !q_full;
			q_data.is_eval = 1'b1;
			q_data.k     = cbe_pkg::K_MAXW'(k_q);
			q_data.u_c   = cbe_pkg::U_MAXW'(u_c_q);
			q_data.u_n   = cbe_pkg::U_MAXW'(u_n_q);
		end else begin
			q_push       = accept && req_type == cbe_pkg::REQ_CP && cp_ok;
			q_data.row   = cbe_pkg::ROW_MAXW'(table_index);
			q_data.ch    = channel_select;
			q_data.value = write_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cbe_pkg::F_IDLE;
		else         state_q <= state_d;
	end

	// search downward, then form offset and segment lengths
	always_ff @(posedge clk) begin
		unique case (state_q)
			cbe_pkg::F_IDLE: begin
				t_q   <= query_time;
				idx_q <= KW'(len_eff - 1'b1);
			end
			cbe_pkg::F_CMP: begin
				if (hit || idx_q == '0) begin
					k_q    <= idx_q;
					base_q <= rdata_q;
					last_q <= (LW+1)'(idx_q) + (LW+1)'(1) >= (LW+1)'(len_eff);
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
			cbe_pkg::F_NXT: begin
				num_q <= $signed({2'b00, t_q}) - base_x;
				if (last_q) begin
					len_c_q <= nxt_x + end_x - base_x;
					len_n_q <= end_x - base_x;
				end else begin
					len_c_q <= nxt_x - base_x;
					len_n_q <= nxt_x - base_x;
				end
			end
			cbe_pkg::F_WC: if (div_done) u_c_q <= div_q;
			cbe_pkg::F_WN: if (div_done) u_n_q <= div_q;
			default: ;
		endcase
	end

	cbe_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_q),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_q)
	);

endmodule

// File: rtl/cbe_fifo.sv
// ----------------------------------------------------------------------------
// cbe_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module cbe_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  cbe_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output cbe_pkg::cmd_t rd_data,
	output logic          empty
);

	localparam int DEPTH = cbe_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	cbe_pkg::cmd_t     mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       count_q;

	assign full    = (count_q == (PW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)      count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en) count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/cbe_back.sv
// ----------------------------------------------------------------------------
// cbe_back
// Holds control points, forms basis weights and sums four points per channel.
// ----------------------------------------------------------------------------
module cbe_back #(
	parameter int MAX_KNOTS    = cbe_pkg::MAX_KNOTS_DEF,
	parameter int MAX_CHANNELS = cbe_pkg::MAX_CHANNELS_DEF,
	parameter int FRAC_BITS    = cbe_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          q_pop,
	input  cbe_pkg::cmd_t q_data,
	input  logic          q_empty,
	input  logic [6:0]    channel_count,
	input  logic [63:0]   noncircular_mask,
	input  logic          pop,
	output logic          empty,
	output logic [5:0]    channel_index,
	output logic signed [31:0] position,
	output logic          last_channel
);

	localparam int KW  = $clog2(MAX_KNOTS);
	localparam int RW  = $clog2(MAX_KNOTS + 3);
	localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NW  = $clog2(MAX_CHANNELS + 1);
	localparam int CP_DEPTH = (MAX_KNOTS + 3) << CHW;
	localparam int UW  = FRAC_BITS + 1;
	localparam int SW  = FRAC_BITS + 5;
	localparam int PRW = UW + 1 + 32;
	localparam int AW  = PRW + 2;
	localparam logic [UW-1:0] ONE_Q  = UW'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;
	localparam logic signed [AW-1:0] HALF_A = AW'(1) << (FRAC_BITS - 1);

	cbe_pkg::back_state_t state_q, state_d;
	cbe_pkg::pow_step_t   sub_q;
	logic                 set_q;
	logic signed [31:0]   cp_mem [CP_DEPTH];
	logic signed [31:0]   cp_rd_q;
	logic [RW+CHW-1:0]    cp_raddr, cp_waddr;
	logic                 cp_we;
	logic [KW-1:0]        k_q;
	logic [UW-1:0]        uc_q, un_q, u_sel, v_sel;
	logic [UW-1:0]        u2_q, u3_q, v2_q, v3_q;
	logic [FRAC_BITS+2:0] raw_q [4];
	logic [UW-1:0]        wc_q [4];
	logic [UW-1:0]        wn_q [4];
	logic [31:0]          mul_a, mul_b;
	logic [63:0]          prod;
	logic signed [SW-1:0] u2_s, u3_s, u_s, v3_s;
	logic [CHW-1:0]       ch_q;
	logic [2:0]           m_q;
	logic [UW-1:0]        w_sel;
	logic signed [PRW-1:0] mprod_q;
	logic signed [AW-1:0] acc_q, rnd;
	logic signed [AW-FRAC_BITS-1:0] shf;
	logic signed [31:0]   res;
	logic [NW-1:0]        nch;
	logic                 last_ch, out_v_q, out_load;
	logic [5:0]           ch_out_q;
	logic signed [31:0]   pos_q;
	logic                 last_out_q;

	// channel count clamped to 1..MAX_CHANNELS
	always_comb begin
		if (channel_count == 7'd0)                       nch = NW'(1);
		else if (32'(channel_count) > 32'(MAX_CHANNELS)) nch = NW'(MAX_CHANNELS);
		else                                             nch = NW'(channel_count);
	end
	assign last_ch = (NW'(ch_q) + NW'(1)) == nch;

	// control point store, registered read
	assign cp_we    = q_pop && !q_data.is_eval;
	assign cp_waddr = {RW'(q_data.row), CHW'(q_data.ch)};
	assign cp_raddr = {RW'(k_q) + RW'(m_q[1:0]), ch_q};
	always_ff @(posedge clk) begin
		if (cp_we) cp_mem[cp_waddr] <= q_data.value;
		cp_rd_q <= cp_mem[cp_raddr];
	end

	// shared multiplier for powers and the divide by six
	assign u_sel = set_q ? un_q : uc_q;
	assign v_sel = ONE_Q - u_sel;
	always_comb begin
		unique case (sub_q)
			cbe_pkg::P_U2: begin mul_a = 32'(u_sel); mul_b = 32'(u_sel); end
			cbe_pkg::P_U3: begin mul_a = 32'(u2_q);  mul_b = 32'(u_sel); end
			cbe_pkg::P_V2: begin mul_a = 32'(v_sel); mul_b = 32'(v_sel); end
			cbe_pkg::P_V3: begin mul_a = 32'(v2_q);  mul_b = 32'(v_sel); end
			cbe_pkg::P_W0: begin mul_a = 32'(raw_q[0]); mul_b = cbe_pkg::RECIP6; end
			cbe_pkg::P_W1: begin mul_a = 32'(raw_q[1]); mul_b = cbe_pkg::RECIP6; end
			cbe_pkg::P_W2: begin mul_a = 32'(raw_q[2]); mul_b = cbe_pkg::RECIP6; end
			cbe_pkg::P_W3: begin mul_a = 32'(raw_q[3]); mul_b = cbe_pkg::RECIP6; end
			default:       begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign prod = 64'(mul_a) * 64'(mul_b);

	assign u2_s = $signed(SW'(u2_q));
	assign u3_s = $signed(SW'(u3_q));
	assign u_s  = $signed(SW'(u_sel));
	assign v3_s = $signed(SW'(v3_q));

	// weight of the current tap for the current channel
	assign w_sel = noncircular_mask[ch_q] ? wn_q[m_q[1:0] - 2'd1] : wc_q[m_q[1:0] - 2'd1];

	// round, floor shift and saturate
	assign rnd = acc_q + HALF_A;
	assign shf = (AW-FRAC_BITS)'(rnd >>> FRAC_BITS);
	always_comb begin
		if (shf > $signed((AW-FRAC_BITS)'(32'sh7FFF_FFFF)))
			res = 32'sh7FFF_FFFF;
		else if (shf < -$signed((AW-FRAC_BITS)'(33'sh0_8000_0000)))
			res = 32'sh8000_0000;
		else
			res = 32'(shf);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cbe_pkg::B_IDLE: if (!q_empty && q_data.is_eval) state_d = cbe_pkg::B_POW;
			cbe_pkg::B_POW:  if (set_q && sub_q == cbe_pkg::P_W3) state_d = cbe_pkg::B_MAC;
			cbe_pkg::B_MAC:  if (m_q == 3'd5) state_d = cbe_pkg::B_OUT;
			cbe_pkg::B_OUT: begin
				if (!out_v_q || pop) state_d = last_ch ? cbe_pkg::B_IDLE : cbe_pkg::B_MAC;
			end
			default: state_d = cbe_pkg::B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop    = (state_q == cbe_pkg::B_IDLE) && !q_empty;
		out_load = (state_q == cbe_pkg::B_OUT) && (!out_v_q || pop);
		empty         = !out_v_q;
		channel_index = ch_out_q;
		position      = pos_q;
		last_channel  = last_out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbe_pkg::B_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)  out_v_q <= 1'b1;
			else if (pop)  out_v_q <= 1'b0;
		end
	end

	// weight sequencer and channel accumulation
	always_ff @(posedge clk) begin
		unique case (state_q)
			cbe_pkg::B_IDLE: begin
				k_q   <= KW'(q_data.k);
				uc_q  <= UW'(q_data.u_c);
				un_q  <= UW'(q_data.u_n);
				set_q <= 1'b0;
				sub_q <= cbe_pkg::P_U2;
				ch_q  <= '0;
				m_q   <= '0;
				acc_q <= '0;
			end
			cbe_pkg::B_POW: begin
				unique case (sub_q)
					cbe_pkg::P_U2: u2_q <= UW'(prod >> FRAC_BITS);
					cbe_pkg::P_U3: u3_q <= UW'(prod >> FRAC_BITS);
					cbe_pkg::P_V2: v2_q <= UW'(prod >> FRAC_BITS);
					cbe_pkg::P_V3: v3_q <= UW'(prod >> FRAC_BITS);
					cbe_pkg::P_SUM: begin
						raw_q[0] <= (FRAC_BITS+3)'(v3_s + SW'(3));
						raw_q[1] <= (FRAC_BITS+3)'(SW'(3) * u3_s - SW'(6) * u2_s
							+ (ONE_S <<< 2) + SW'(3));
						raw_q[2] <= (FRAC_BITS+3)'(-(SW'(3) * u3_s) + SW'(3) * u2_s
							+ SW'(3) * u_s + ONE_S + SW'(3));
						raw_q[3] <= (FRAC_BITS+3)'(u3_s + SW'(3));
					end
					cbe_pkg::P_W0: if (set_q) wn_q[0] <= UW'(prod >> cbe_pkg::RECIP6_SHIFT);
						else wc_q[0] <= UW'(prod >> cbe_pkg::RECIP6_SHIFT);
					cbe_pkg::P_W1: if (set_q) wn_q[1] <= UW'(prod >> cbe_pkg::RECIP6_SHIFT);
						else wc_q[1] <= UW'(prod >> cbe_pkg::RECIP6_SHIFT);
					cbe_pkg::P_W2: if (set_q) wn_q[2] <= UW'(prod >> cbe_pkg::RECIP6_SHIFT);
						else wc_q[2] <= UW'(prod >> cbe_pkg::RECIP6_SHIFT);
					cbe_pkg::P_W3: if (set_q) wn_q[3] <= UW'(prod >> cbe_pkg::RECIP6_SHIFT);
						else wc_q[3] <= UW'(prod >> cbe_pkg::RECIP6_SHIFT);
					default: ;
				endcase
				if (sub_q == cbe_pkg::P_W3) begin
					set_q <= 1'b1;
					sub_q <= cbe_pkg::P_U2;
				end else begin
					sub_q <= cbe_pkg::pow_step_t'(sub_q + 4'd1);
				end
			end
			cbe_pkg::B_MAC: begin
				m_q <= m_q + 3'd1;
				if (m_q >= 3'd1 && m_q <= 3'd4)
					mprod_q <= $signed({1'b0, w_sel}) * cp_rd_q;
				if (m_q >= 3'd2)
					acc_q <= acc_q + AW'(mprod_q);
			end
			cbe_pkg::B_OUT: begin
				if (!out_v_q || pop) begin
					ch_out_q   <= 6'(ch_q);
					pos_q      <= res;
					last_out_q <= last_ch;
					ch_q       <= ch_q + 1'b1;
					m_q        <= '0;
					acc_q      <= '0;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/cubic_bspline_evaluator.sv
// ----------------------------------------------------------------------------
// cubic_bspline_evaluator
// Uniform cubic B-spline evaluation over loaded knots and control points.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  config    psel/penable/pready    paddr, pwdata, prdata (64 bit, regs at 8*i)
//  input     push / full            req_type, table_index, channel_select,
//                                   write_value, query_time
//  result    empty / pop            channel_index, position, last_channel
//
// A knot write goes straight into the front's table; a control point write passes
// through the command queue to the back. A query scans the knots from the top
// down, then runs two one-bit-per-cycle divisions in the front; the back then
// forms the weights and sums four taps per channel.
// Reset clears control only; both tables read undefined until written.
// A stalled result holds the back; the command queue lets the front go on.
// ----------------------------------------------------------------------------
module cubic_bspline_evaluator #(
	parameter int MAX_KNOTS    = cbe_pkg::MAX_KNOTS_DEF,
	parameter int MAX_CHANNELS = cbe_pkg::MAX_CHANNELS_DEF,
	parameter int FRAC_BITS    = cbe_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         req_type,
	input  logic [8:0]         table_index,
	input  logic [5:0]         channel_select,
	input  logic signed [31:0] write_value,
	input  logic [31:0]        query_time,
	input  logic               pop,
	output logic               empty,
	output logic [5:0]         channel_index,
	output logic signed [31:0] position,
	output logic               last_channel
);

	logic [31:0]   end_time_q;
	logic [8:0]    knot_count_q;
	logic [6:0]    channel_count_q;
	logic [63:0]   nc_mask_q;
	logic          cfg_we;
	cbe_pkg::cfg_reg_t reg_sel;
	logic          q_push, q_full, q_pop, q_empty;
	cbe_pkg::cmd_t q_wdata, q_rdata;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign reg_sel = cbe_pkg::cfg_reg_t'(paddr[4:3]);

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_time_q      <= '0;
			knot_count_q    <= 9'd1;
			channel_count_q <= 7'd1;
			nc_mask_q       <= '0;
		end else if (cfg_we) begin
			unique case (reg_sel)
				cbe_pkg::REG_END_TIME: end_time_q      <= pwdata[31:0];
				cbe_pkg::REG_KNOT_CNT: knot_count_q    <= pwdata[8:0];
				cbe_pkg::REG_CHAN_CNT: channel_count_q <= pwdata[6:0];
				cbe_pkg::REG_NC_MASK:  nc_mask_q       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			cbe_pkg::REG_END_TIME: prdata = 64'(end_time_q);
			cbe_pkg::REG_KNOT_CNT: prdata = 64'(knot_count_q);
			cbe_pkg::REG_CHAN_CNT: prdata = 64'(channel_count_q);
			cbe_pkg::REG_NC_MASK:  prdata = nc_mask_q;
			default:               prdata = '0;
		endcase
	end

	cbe_front #(
		.MAX_KNOTS(MAX_KNOTS), .MAX_CHANNELS(MAX_CHANNELS), .FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.req_type      (req_type),
		.table_index   (table_index),
		.channel_select(channel_select),
		.write_value   (write_value),
		.query_time    (query_time),
		.end_time      (end_time_q),
		.knot_count    (knot_count_q),
		.q_push        (q_push),
		.q_data        (q_wdata),
		.q_full        (q_full)
	);

	cbe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wdata),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rdata),
		.empty  (q_empty)
	);

	cbe_back #(
		.MAX_KNOTS(MAX_KNOTS), .MAX_CHANNELS(MAX_CHANNELS), .FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_pop           (q_pop),
		.q_data          (q_rdata),
		.q_empty         (q_empty),
		.channel_count   (channel_count_q),
		.noncircular_mask(nc_mask_q),
		.pop             (pop),
		.empty           (empty),
		.channel_index   (channel_index),
		.position        (position),
		.last_channel    (last_channel)
	);

endmodule

// File: rtl/cbe_checker.sv
// ----------------------------------------------------------------------------
// cbe_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module cbe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pready,
	input logic               full,
	input logic               pop,
	input logic               empty,
	input logic [5:0]         channel_index,
	input logic signed [31:0] position,
	input logic               last_channel
);

	// reset leaves no result and an open input
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("result or stall present during reset");

	// a waiting result stays until taken
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped without transfer");

	// a waiting result holds its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(position) && $stable(channel_index)
			&& $stable(last_channel))
		else $error("result payload changed while waiting");

	// config port never inserts wait states
	a_no_wait: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("config port stalled");

endmodule

bind cubic_bspline_evaluator cbe_checker u_cbe_checker (.*);
